FILE: src/cbv_pkg.sv
package cbv_pkg;

    localparam int SIZE_BITS  = 24;
    localparam int MAX_DIGITS = 7;
    localparam int DCNT_BITS  = 4;
    localparam int LEN_BITS   = 32;

    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_D0 = 8'h30;
    localparam logic [7:0] CH_D9 = 8'h39;

    typedef enum logic [2:0] {
        PH_SIZE     = 3'd0,
        PH_SIZE_LF  = 3'd1,
        PH_DATA     = 3'd2,
        PH_DATA_LF  = 3'd3,
        PH_TRAIL_CR = 3'd4,
        PH_TRAIL_LF = 3'd5,
        PH_OVER     = 3'd6,
        PH_OVER_LF  = 3'd7
    } t_phase;

    typedef enum logic [1:0] {
        ST_CONT = 2'd0,
        ST_DONE = 2'd1,
        ST_BAD  = 2'd2,
        ST_MORE = 2'd3
    } t_status;

    typedef struct packed {
        logic       is_cr;
        logic       is_lf;
        logic       is_digit;
        logic [3:0] digit;
        logic       first;
        logic       last;
    } t_item;

endpackage

FILE: src/chunked_body_validator.sv
// a result reaches the outputs through the queue, then the output register
// throughput: 1 byte per cycle while i_stall is low, set by the parser update in the back end
// a 2-entry queue between byte intake and parser lets each side stall on its own
// reset (synchronous, active low) empties the queue, drops output valid and
// returns the parser to the size line with all counts at zero
module chunked_body_validator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_first_byte,
    input  logic        i_last_available,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic [31:0] o_body_length
);

    cbv_pkg::t_item w_in_item;
    cbv_pkg::t_item w_q_item;
    logic           w_push;
    logic           w_full;
    logic           w_pop;
    logic           w_avail;

    cbv_front u_front (
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_data_byte      (i_data_byte),
        .i_first_byte     (i_first_byte),
        .i_last_available (i_last_available),
        .o_push           (w_push),
        .o_item           (w_in_item),
        .i_full           (w_full)
    );

    cbv_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_in_item),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_avail (w_avail),
        .o_item  (w_q_item)
    );

    cbv_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_avail       (w_avail),
        .i_item        (w_q_item),
        .o_pop         (w_pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_status      (o_status),
        .o_body_length (o_body_length)
    );

endmodule

FILE: src/cbv_front.sv
module cbv_front (
    input  logic           i_valid,
    output logic           o_stall,
    input  logic [7:0]     i_data_byte,
    input  logic           i_first_byte,
    input  logic           i_last_available,
    output logic           o_push,
    output cbv_pkg::t_item o_item,
    input  logic           i_full
);

    logic [7:0] w_sub;

    assign o_stall = i_full;
    assign o_push  = i_valid && !i_full;
    assign w_sub   = i_data_byte - cbv_pkg::CH_D0;

    always_comb begin
        o_item.is_cr    = (i_data_byte == cbv_pkg::CH_CR);
        o_item.is_lf    = (i_data_byte == cbv_pkg::CH_LF);
        o_item.is_digit = (i_data_byte >= cbv_pkg::CH_D0) && (i_data_byte <= cbv_pkg::CH_D9);
        o_item.digit    = w_sub[3:0];
        o_item.first    = i_first_byte;
        o_item.last     = i_last_available;
    end

endmodule

FILE: src/cbv_queue.sv
module cbv_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  cbv_pkg::t_item i_item,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_avail,
    output cbv_pkg::t_item o_item
);

    cbv_pkg::t_item r_mem [2];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;
    logic [1:0]     n_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_avail = (r_cnt != 2'd0);
    assign o_item  = r_mem[r_rp];

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= n_cnt;
        end
    end

endmodule

FILE: src/cbv_back.sv
module cbv_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_avail,
    input  cbv_pkg::t_item               i_item,
    output logic                         o_pop,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [1:0]                   o_status,
    output logic [cbv_pkg::LEN_BITS-1:0] o_body_length
);

    localparam int VB = cbv_pkg::SIZE_BITS + 4;

    cbv_pkg::t_phase                r_phase, n_phase, w_phase;
    cbv_pkg::t_status               r_sticky, n_sticky, w_sticky, w_st;
    logic [cbv_pkg::SIZE_BITS-1:0]  r_chunk, n_chunk, w_chunk;
    logic [cbv_pkg::SIZE_BITS-1:0]  r_dcnt, n_dcnt, w_dcnt;
    logic [cbv_pkg::DCNT_BITS-1:0]  r_digits, n_digits, w_digits;
    logic [cbv_pkg::LEN_BITS-1:0]   r_cons, n_cons, w_cons;
    logic [VB-1:0]                  w_v;
    logic                           r_ovalid;
    logic [1:0]                     r_ostatus, n_ostatus;
    logic [cbv_pkg::LEN_BITS-1:0]   r_olen, n_olen;

    assign o_pop         = i_avail && (!r_ovalid || !i_stall);
    assign o_valid       = r_ovalid;
    assign o_status      = r_ostatus;
    assign o_body_length = r_olen;

    always_comb begin
        if (i_item.first) begin
            w_phase  = cbv_pkg::PH_SIZE;
            w_sticky = cbv_pkg::ST_CONT;
            w_chunk  = '0;
            w_dcnt   = '0;
            w_digits = '0;
            w_cons   = '0;
        end else begin
            w_phase  = r_phase;
            w_sticky = r_sticky;
            w_chunk  = r_chunk;
            w_dcnt   = r_dcnt;
            w_digits = r_digits;
            w_cons   = r_cons;
        end
        w_v = {1'b0, w_chunk, 3'b000} + {3'b000, w_chunk, 1'b0}
            + {{(VB-4){1'b0}}, i_item.digit};

        n_phase  = w_phase;
        n_sticky = w_sticky;
        n_chunk  = w_chunk;
        n_dcnt   = w_dcnt;
        n_digits = w_digits;
        n_cons   = w_cons;
        w_st     = cbv_pkg::ST_CONT;

        if (w_sticky != cbv_pkg::ST_CONT) begin
            n_ostatus = w_sticky;
            n_olen    = (w_sticky == cbv_pkg::ST_DONE) ? w_cons : '0;
        end else begin
            if (w_cons != '1) begin
                n_cons = w_cons + cbv_pkg::LEN_BITS'(1);
            end
            case (w_phase)
                cbv_pkg::PH_SIZE: begin
                    if (i_item.is_cr) begin
                        if (w_digits == '0) begin
                            w_st = cbv_pkg::ST_BAD;
                        end else begin
                            n_phase = cbv_pkg::PH_SIZE_LF;
                        end
                    end else if (i_item.is_digit) begin
                        if (w_digits >= cbv_pkg::DCNT_BITS'(cbv_pkg::MAX_DIGITS)
                            || w_v[VB-1:cbv_pkg::SIZE_BITS] != '0) begin
                            w_st = cbv_pkg::ST_BAD;
                        end else begin
                            n_chunk  = w_v[cbv_pkg::SIZE_BITS-1:0];
                            n_digits = w_digits + cbv_pkg::DCNT_BITS'(1);
                        end
                    end else begin
                        w_st = cbv_pkg::ST_BAD;
                    end
                end
                cbv_pkg::PH_SIZE_LF: begin
                    if (!i_item.is_lf) begin
                        w_st = cbv_pkg::ST_BAD;
                    end else if (w_chunk == '0) begin
                        n_phase = cbv_pkg::PH_TRAIL_CR;
                    end else begin
                        n_phase = cbv_pkg::PH_DATA;
                        n_dcnt  = '0;
                    end
                end
                cbv_pkg::PH_DATA: begin
                    if (i_item.is_cr) begin
                        n_phase = cbv_pkg::PH_DATA_LF;
                    end else if (w_dcnt >= w_chunk) begin
                        n_phase = cbv_pkg::PH_OVER;
                    end else begin
                        n_dcnt = w_dcnt + cbv_pkg::SIZE_BITS'(1);
                    end
                end
                cbv_pkg::PH_DATA_LF: begin
                    if (!i_item.is_lf || w_dcnt != w_chunk) begin
                        w_st = cbv_pkg::ST_BAD;
                    end else begin
                        n_phase  = cbv_pkg::PH_SIZE;
                        n_chunk  = '0;
                        n_digits = '0;
                        n_dcnt   = '0;
                    end
                end
                cbv_pkg::PH_TRAIL_CR: begin
                    if (i_item.is_cr) begin
                        n_phase = cbv_pkg::PH_TRAIL_LF;
                    end else begin
                        w_st = cbv_pkg::ST_BAD;
                    end
                end
                cbv_pkg::PH_TRAIL_LF: begin
                    w_st = i_item.is_lf ? cbv_pkg::ST_DONE : cbv_pkg::ST_BAD;
                end
                cbv_pkg::PH_OVER: begin
                    if (i_item.is_cr) begin
                        n_phase = cbv_pkg::PH_OVER_LF;
                    end
                end
                default: begin
                    w_st = cbv_pkg::ST_BAD;
                end
            endcase
            if (w_st != cbv_pkg::ST_CONT) begin
                n_sticky = w_st;
            end else if (i_item.last) begin
                w_st = cbv_pkg::ST_MORE;
            end
            n_ostatus = w_st;
            n_olen    = (w_st == cbv_pkg::ST_DONE) ? n_cons : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_ostatus <= n_ostatus;
            r_olen    <= n_olen;
        end
        if (!i_rst_n) begin
            r_phase  <= cbv_pkg::PH_SIZE;
            r_sticky <= cbv_pkg::ST_CONT;
            r_chunk  <= '0;
            r_dcnt   <= '0;
            r_digits <= '0;
            r_cons   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_phase  <= n_phase;
                r_sticky <= n_sticky;
                r_chunk  <= n_chunk;
                r_dcnt   <= n_dcnt;
                r_digits <= n_digits;
                r_cons   <= n_cons;
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

endmodule

FILE: src/cbv_checker.sv
module cbv_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [1:0]  o_status,
    input logic [31:0] o_body_length
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_status) && $stable(o_body_length))
        else $error("stalled result changed");

    a_len_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != cbv_pkg::ST_DONE |-> o_body_length == 32'd0)
        else $error("body length set without completion");

    a_len_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == cbv_pkg::ST_DONE |-> o_body_length >= 32'd5)
        else $error("completed body shorter than final line");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("reset left a result or a stall");

endmodule

bind chunked_body_validator cbv_checker u_cbv_checker (.*);
